// File: sv/mpsm_pkg.sv
// Shared types, codes and defaults of the multi-pattern string matcher.
package mpsm_pkg;

  localparam int unsigned DefMaxStates    = 256;
  localparam int unsigned DefAlphabet     = 128;
  localparam int unsigned DefMaxPatternLen = 32;

  localparam int unsigned ResMax   = 32;
  localparam int unsigned ResCntW  = $clog2(ResMax + 1);

  localparam logic [1:0] ReqClear  = 2'd0;
  localparam logic [1:0] ReqInsert = 2'd1;
  localparam logic [1:0] ReqBuild  = 2'd2;
  localparam logic [1:0] ReqText   = 2'd3;

  localparam logic [1:0] KindDone  = 2'd0;
  localparam logic [1:0] KindMatch = 2'd1;
  localparam logic [1:0] KindNone  = 2'd2;
  localparam logic [1:0] KindFull  = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] symbol;
    logic       last_char;
    logic       text_start;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pattern_id;
    logic [15:0] start_pos;
    logic        last;
  } res_t;

endpackage

// File: sv/mpsm_engine.sv
// Sequencer and trie memories: clear sweep, insert, breadth-first link build and text scan.
module mpsm_engine #(
  parameter int unsigned MAX_STATES      = mpsm_pkg::DefMaxStates,
  parameter int unsigned ALPHABET        = mpsm_pkg::DefAlphabet,
  parameter int unsigned MAX_PATTERN_LEN = mpsm_pkg::DefMaxPatternLen
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  mpsm_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output mpsm_pkg::res_t res_o
);

  localparam int unsigned NW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned GW = NW + AW;
  localparam int unsigned DW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned KW = mpsm_pkg::ResCntW;

  typedef enum logic [20:0] {
    S_CLR  = 21'h000001, S_IDLE = 21'h000002, S_I0   = 21'h000004,
    S_I1   = 21'h000008, S_B0   = 21'h000010, S_BPOP = 21'h000020,
    S_BU   = 21'h000040, S_BC0  = 21'h000080, S_BC1  = 21'h000100,
    S_BF0  = 21'h000200, S_BF1  = 21'h000400, S_BF2  = 21'h000800,
    S_BS0  = 21'h001000, S_BS1  = 21'h002000, S_T0   = 21'h004000,
    S_T1   = 21'h008000, S_T2   = 21'h010000, S_M0   = 21'h020000,
    S_M1   = 21'h040000, S_EMID = 21'h080000, S_EFIN = 21'h100000
  } state_e;

  state_e st_q, st_d;

  // Memories.
  logic [NW-1:0] goto_mem [2**GW];
  logic [NW-1:0] fail_mem [MAX_STATES];
  logic [NW-1:0] dict_mem [MAX_STATES];
  logic          has_mem  [MAX_STATES];
  logic [7:0]    id_mem   [MAX_STATES];
  logic [DW-1:0] dep_mem  [MAX_STATES];
  logic [NW-1:0] que_mem  [MAX_STATES];

  logic [NW-1:0] goto_rd, fail_rd, dict_rd, que_rd;
  logic          has_rd;
  logic [7:0]    id_rd;
  logic [DW-1:0] dep_rd;

  // Control and working registers.
  logic [GW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_emit_q, clr_emit_d;
  logic [NW:0]   node_cnt_q, node_cnt_d;
  logic [7:0]    pat_cnt_q, pat_cnt_d;
  logic [NW-1:0] ins_cur_q, ins_cur_d;
  logic [NW-1:0] cur_q, cur_d;
  logic [15:0]   pos_q, pos_d;
  logic [NW:0]   head_q, head_d, tail_q, tail_d;
  logic [NW-1:0] u_q, u_d, v_q, v_d, f_q, f_d, n_q, n_d;
  logic [AW-1:0] c_q, c_d;
  logic          c_bad_q, c_bad_d;
  logic          last_q, last_d;
  logic [KW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic [7:0]    pend_id_q, pend_id_d;
  logic [15:0]   pend_pos_q, pend_pos_d;
  mpsm_pkg::res_t res_q, res_d;

  // Read addresses.
  logic [GW-1:0] goto_ra;
  logic [NW-1:0] fail_ra, dep_ra, node_ra;

  // Write ports.
  logic          goto_we, fail_we, dict_we, has_we, id_we, dep_we, que_we;
  logic [GW-1:0] goto_wa;
  logic [NW-1:0] goto_wd, fail_wa, fail_wd, dict_wa, dict_wd, has_wa, id_wa, dep_wa;
  logic [NW-1:0] que_wa, que_wd;
  logic          has_wd;
  logic [DW-1:0] dep_wd;

  logic [8:0]    sym_ext;
  logic [7:0]    sym8;
  logic          ins_err;
  logic          ins_create;
  logic [NW-1:0] ins_next;
  logic [NW-1:0] nc_idx;
  logic [16:0]   start_ext;
  logic [15:0]   match_pos;

  assign sym_ext = {2'b00, req_i.symbol};
  assign sym8    = {1'b0, req_i.symbol};
  assign nc_idx  = node_cnt_q[NW-1:0];

  // Insert decision, valid in S_I1 once the goto entry and depth are read.
  always_comb begin
    ins_err    = 1'b0;
    ins_create = 1'b0;
    ins_next   = ins_cur_q;
    if (c_bad_q || (dep_rd >= DW'(MAX_PATTERN_LEN))) begin
      ins_err = 1'b1;
    end else if (goto_rd == '0) begin
      if (node_cnt_q >= (NW+1)'(MAX_STATES)) begin
        ins_err = 1'b1;
      end else begin
        ins_create = 1'b1;
        ins_next   = nc_idx;
      end
    end else begin
      ins_next = goto_rd;
    end
  end

  // The start position counts back from the current position by the node depth.
  always_comb begin
    start_ext = {1'b0, pos_q} - 17'(dep_rd) + 17'd1;
    match_pos = (17'(dep_rd) <= {1'b0, pos_q}) ? start_ext[15:0] : 16'd0;
  end

  always_comb begin
    goto_ra = {v_q, c_q};
    fail_ra = cur_q;
    dep_ra  = n_q;
    node_ra = n_q;
    case (st_q)
      S_I0:    begin goto_ra = {ins_cur_q, c_q}; dep_ra = ins_cur_q; end
      S_BC0:   begin goto_ra = {u_q, c_q}; fail_ra = u_q; end
      S_BF0:   goto_ra = {f_q, c_q};
      S_BF1:   fail_ra = f_q;
      S_BS0:   node_ra = f_q;
      S_T0:    goto_ra = {cur_q, c_q};
      default: ;
    endcase
  end

  always_comb begin
    goto_we = 1'b0; goto_wa = clr_cnt_q; goto_wd = '0;
    fail_we = 1'b0; fail_wa = '0; fail_wd = '0;
    dict_we = 1'b0; dict_wa = '0; dict_wd = '0;
    has_we  = 1'b0; has_wa  = '0; has_wd  = 1'b0;
    id_we   = 1'b0; id_wa   = ins_next; 
    dep_we  = 1'b0; dep_wa  = '0; dep_wd  = '0;
    que_we  = 1'b0; que_wa  = '0; que_wd  = '0;
    case (st_q)
      S_CLR: begin
        goto_we = 1'b1;
        fail_we = 1'b1;
        dict_we = 1'b1;
        has_we  = 1'b1;
        dep_we  = 1'b1;
      end
      S_I1: begin
        goto_we = ins_create;
        goto_wa = {ins_cur_q, c_q};
        goto_wd = nc_idx;
        fail_we = ins_create; fail_wa = nc_idx;
        dict_we = ins_create; dict_wa = nc_idx;
        dep_we  = ins_create; dep_wa  = nc_idx; dep_wd = dep_rd + DW'(1);
        has_we  = ins_create || (last_q && !ins_err);
        has_wa  = ins_next;
        has_wd  = last_q && !ins_err;
        id_we   = last_q && !ins_err;
      end
      S_B0: que_we = 1'b1;
      S_BS1: begin
        fail_we = 1'b1; fail_wa = v_q; fail_wd = f_q;
        dict_we = 1'b1; dict_wa = v_q; dict_wd = has_rd ? f_q : dict_rd;
        que_we  = 1'b1; que_wa  = tail_q[NW-1:0]; que_wd = v_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) begin
      goto_mem[goto_wa] <= goto_wd;
    end
    goto_rd <= goto_mem[goto_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[dict_wa] <= dict_wd;
    end
    dict_rd <= dict_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (has_we) begin
      has_mem[has_wa] <= has_wd;
    end
    has_rd <= has_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[id_wa] <= pat_cnt_q;
    end
    id_rd <= id_mem[node_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[dep_wa] <= dep_wd;
    end
    dep_rd <= dep_mem[dep_ra];
  end

  always_ff @(posedge clk_i) begin
    if (que_we) begin
      que_mem[que_wa] <= que_wd;
    end
    que_rd <= que_mem[head_q[NW-1:0]];
  end

  assign req_ready_o = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_EMID) || (st_q == S_EFIN);
  assign res_o       = res_q;

  always_comb begin
    st_d       = st_q;
    clr_cnt_d  = clr_cnt_q;
    clr_emit_d = clr_emit_q;
    node_cnt_d = node_cnt_q;
    pat_cnt_d  = pat_cnt_q;
    ins_cur_d  = ins_cur_q;
    cur_d      = cur_q;
    pos_d      = pos_q;
    head_d     = head_q;
    tail_d     = tail_q;
    u_d        = u_q;
    v_d        = v_q;
    f_d        = f_q;
    n_d        = n_q;
    c_d        = c_q;
    c_bad_d    = c_bad_q;
    last_d     = last_q;
    k_d        = k_q;
    pend_d     = pend_q;
    pend_id_d  = pend_id_q;
    pend_pos_d = pend_pos_q;
    res_d      = res_q;
    case (st_q)
      S_CLR: begin
        clr_cnt_d = clr_cnt_q + GW'(1);
        if (clr_cnt_q == '1) begin
          res_d = '{kind: mpsm_pkg::KindDone, pattern_id: 8'd0, start_pos: 16'd0, last: 1'b1};
          st_d  = clr_emit_q ? S_EFIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          c_d     = AW'(sym8);
          c_bad_d = (sym_ext >= 9'(ALPHABET));
          last_d  = req_i.last_char;
          case (req_i.req_type)
            mpsm_pkg::ReqClear: begin
              clr_cnt_d  = '0;
              clr_emit_d = 1'b1;
              node_cnt_d = (NW+1)'(1);
              pat_cnt_d  = '0;
              ins_cur_d  = '0;
              cur_d      = '0;
              pos_d      = '0;
              head_d     = '0;
              tail_d     = '0;
              st_d       = S_CLR;
            end
            mpsm_pkg::ReqInsert: st_d = S_I0;
            mpsm_pkg::ReqBuild:  st_d = S_B0;
            default: begin
              if (req_i.text_start) begin
                pos_d = 16'd1;
              end else if (pos_q != 16'hFFFF) begin
                pos_d = pos_q + 16'd1;
              end
              k_d    = '0;
              pend_d = 1'b0;
              if (sym_ext >= 9'(ALPHABET)) begin
                cur_d = '0;
                n_d   = '0;
                st_d  = S_M0;
              end else begin
                if (req_i.text_start) begin
                  cur_d = '0;
                end
                st_d = S_T0;
              end
            end
          endcase
        end
      end
      S_I0: st_d = S_I1;
      S_I1: begin
        if (ins_create) begin
          node_cnt_d = node_cnt_q + (NW+1)'(1);
        end
        ins_cur_d = last_q ? '0 : ins_next;
        if (last_q && !ins_err) begin
          pat_cnt_d = pat_cnt_q + 8'd1;
        end
        res_d = '{kind: (ins_err ? mpsm_pkg::KindFull : mpsm_pkg::KindDone),
                  pattern_id: 8'd0, start_pos: 16'd0, last: 1'b1};
        st_d  = S_EFIN;
      end
      S_B0: begin
        head_d = '0;
        tail_d = (NW+1)'(1);
        st_d   = S_BPOP;
      end
      S_BPOP: begin
        if (head_q == tail_q) begin
          res_d = '{kind: mpsm_pkg::KindDone, pattern_id: 8'd0, start_pos: 16'd0, last: 1'b1};
          st_d  = S_EFIN;
        end else begin
          st_d = S_BU;
        end
      end
      S_BU: begin
        u_d    = que_rd;
        head_d = head_q + (NW+1)'(1);
        c_d    = '0;
        st_d   = S_BC0;
      end
      S_BC0: st_d = S_BC1;
      S_BC1: begin
        v_d = goto_rd;
        if (goto_rd == '0) begin
          c_d  = c_q + AW'(1);
          st_d = (c_q == AW'(ALPHABET - 1)) ? S_BPOP : S_BC0;
        end else if (u_q == '0) begin
          f_d  = '0;
          st_d = S_BS0;
        end else begin
          f_d  = fail_rd;
          st_d = S_BF0;
        end
      end
      S_BF0: st_d = S_BF1;
      S_BF1: begin
        if (f_q != '0 && goto_rd == '0) begin
          st_d = S_BF2;
        end else begin
          f_d  = (goto_rd != '0 && goto_rd != v_q) ? goto_rd : '0;
          st_d = S_BS0;
        end
      end
      S_BF2: begin
        f_d  = fail_rd;
        st_d = S_BF0;
      end
      S_BS0: st_d = S_BS1;
      S_BS1: begin
        tail_d = tail_q + (NW+1)'(1);
        c_d    = c_q + AW'(1);
        st_d   = (c_q == AW'(ALPHABET - 1)) ? S_BPOP : S_BC0;
      end
      S_T0: st_d = S_T1;
      S_T1: begin
        if (cur_q != '0 && goto_rd == '0) begin
          st_d = S_T2;
        end else begin
          cur_d = goto_rd;
          n_d   = goto_rd;
          st_d  = S_M0;
        end
      end
      S_T2: begin
        cur_d = fail_rd;
        st_d  = S_T0;
      end
      S_M0: begin
        if (n_q == '0 || k_q == KW'(mpsm_pkg::ResMax)) begin
          if (pend_q) begin
            res_d = '{kind: mpsm_pkg::KindMatch, pattern_id: pend_id_q,
                      start_pos: pend_pos_q, last: 1'b1};
          end else begin
            res_d = '{kind: mpsm_pkg::KindNone, pattern_id: 8'd0, start_pos: 16'd0, last: 1'b1};
          end
          st_d = S_EFIN;
        end else begin
          st_d = S_M1;
        end
      end
      S_M1: begin
        n_d  = dict_rd;
        st_d = S_M0;
        if (has_rd) begin
          // The previous match goes out only now that a later one is known.
          k_d        = k_q + KW'(1);
          pend_d     = 1'b1;
          pend_id_d  = id_rd;
          pend_pos_d = match_pos;
          if (pend_q) begin
            res_d = '{kind: mpsm_pkg::KindMatch, pattern_id: pend_id_q,
                      start_pos: pend_pos_q, last: 1'b0};
            st_d  = S_EMID;
          end
        end
      end
      S_EMID: begin
        if (res_ready_i) begin
          st_d = S_M0;
        end
      end
      S_EFIN: begin
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_CLR;
      clr_cnt_q  <= '0;
      clr_emit_q <= 1'b0;
      node_cnt_q <= (NW+1)'(1);
      pat_cnt_q  <= '0;
      ins_cur_q  <= '0;
      cur_q      <= '0;
      pos_q      <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      k_q        <= '0;
      pend_q     <= 1'b0;
    end else begin
      st_q       <= st_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_emit_q <= clr_emit_d;
      node_cnt_q <= node_cnt_d;
      pat_cnt_q  <= pat_cnt_d;
      ins_cur_q  <= ins_cur_d;
      cur_q      <= cur_d;
      pos_q      <= pos_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      k_q        <= k_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    f_q        <= f_d;
    n_q        <= n_d;
    c_q        <= c_d;
    c_bad_q    <= c_bad_d;
    last_q     <= last_d;
    pend_id_q  <= pend_id_d;
    pend_pos_q <= pend_pos_d;
    res_q      <= res_d;
  end

  a_cur_in_trie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_q} < node_cnt_q) && ({1'b0, ins_cur_q} < node_cnt_q))
    else $error("automaton or insert cursor points past the allocated nodes");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q <= node_cnt_q) && (head_q <= tail_q))
    else $error("breadth-first queue pointers out of range");

  a_match_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_M1) |-> (k_q < KW'(mpsm_pkg::ResMax)))
    else $error("match chain walked past the result limit");

  a_node_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_cnt_q <= (NW+1)'(MAX_STATES))
    else $error("node count exceeds table size");

endmodule

// File: sv/multi_pattern_string_matcher_top.sv
// Top level of the multi-pattern string matcher with its result register.
// Aho-Corasick matcher over 7-bit characters. After reset, and after every clear
// request, the goto table is swept one entry per cycle (MAX_STATES and the alphabet
// each rounded up to a power of two and multiplied: 32768 entries at the defaults)
// and no request is taken meanwhile. One request is handled at a time through a
// single-port read on each trie memory. An insert reads the goto entry and depth
// at the cursor, then follows or adds the child and returns its result; a text
// character follows failure links until a goto entry or the root is reached, then
// walks the dictionary-suffix chain with a result per match or a no-match result;
// a build takes each node from the queue, visits each (node, character) pair and,
// for each child, follows failure links, writes its failure and dictionary links
// and queues it. A stalled output holds the engine until its result is taken. A
// result waits in the output register while the next request is accepted.
module multi_pattern_string_matcher_top #(
  parameter int unsigned MAX_STATES      = mpsm_pkg::DefMaxStates,
  parameter int unsigned ALPHABET        = mpsm_pkg::DefAlphabet,
  parameter int unsigned MAX_PATTERN_LEN = mpsm_pkg::DefMaxPatternLen
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mpsm_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mpsm_pkg::res_t out_res_o
);

  logic           res_valid, res_ready;
  mpsm_pkg::res_t res;
  logic           out_valid_q;
  mpsm_pkg::res_t out_res_q;

  mpsm_engine #(
    .MAX_STATES     (MAX_STATES),
    .ALPHABET       (ALPHABET),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_o(in_ready_o),
    .req_i      (in_req_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the multi-pattern string matcher top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NStates  = mpsm_pkg::DefMaxStates;
  localparam int unsigned NSymbols = mpsm_pkg::DefAlphabet;
  localparam int unsigned MaxLen   = mpsm_pkg::DefMaxPatternLen;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned LongHold = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  mpsm_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  mpsm_pkg::res_t out_res_o;

  multi_pattern_string_matcher_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state of the automaton.
  logic [7:0]  trie_next [NStates*NSymbols];
  logic [7:0]  fail_of [NStates];
  logic [7:0]  suffix_of [NStates];
  logic        is_final [NStates];
  logic [7:0]  pat_of [NStates];
  logic [5:0]  depth_of [NStates];
  logic [7:0]  bfs_fifo [NStates];
  int unsigned nodes_used;
  logic [7:0]  next_pat_id;
  int unsigned ins_node;
  int unsigned cur_node;
  int unsigned pos_in_text;

  mpsm_pkg::res_t match_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_gen = 0;
  int unsigned burst_left = 0;

  typedef struct packed {
    mpsm_pkg::req_t r;
    bit             typed;
    mpsm_pkg::res_t want;
  } row_t;

  row_t rows [$];

  function automatic mpsm_pkg::res_t mk(logic [1:0] kind, logic [7:0] id, logic [15:0] pos,
                                        logic lst);
    mpsm_pkg::res_t r;
    r.kind = kind;
    r.pattern_id = id;
    r.start_pos = pos;
    r.last = lst;
    return r;
  endfunction

  function automatic void expect_res(mpsm_pkg::res_t r);
    match_q = {match_q, r};
  endfunction

  function automatic void add_row(mpsm_pkg::req_t r, bit typed, mpsm_pkg::res_t want);
    row_t row;
    row.r = r;
    row.typed = typed;
    row.want = want;
    rows = {rows, row};
  endfunction

  function automatic int unsigned next_of(int unsigned node, int unsigned c);
    if (node >= NStates || c >= NSymbols) return 0;
    return trie_next[node*NSymbols + c];
  endfunction

  function automatic void wipe_trie();
    for (int i = 0; i < NStates*NSymbols; i++) trie_next[i] = '0;
    for (int i = 0; i < NStates; i++) begin
      fail_of[i] = '0;
      suffix_of[i] = '0;
      is_final[i] = 1'b0;
      pat_of[i] = '0;
      depth_of[i] = '0;
      bfs_fifo[i] = '0;
    end
    nodes_used = 1;
    next_pat_id = '0;
    ins_node = 0;
    cur_node = 0;
    pos_in_text = 0;
  endfunction

  function automatic logic [1:0] add_char(int unsigned c, bit lst);
    bit err;
    int unsigned cur, nx;
    err = 1'b0;
    cur = ins_node % NStates;
    if (c >= NSymbols || depth_of[cur] >= MaxLen) begin
      err = 1'b1;
    end else begin
      nx = next_of(cur, c);
      if (nx == 0) begin
        if (nodes_used >= NStates) begin
          err = 1'b1;
        end else begin
          nx = nodes_used++;
          trie_next[cur*NSymbols + c] = nx[7:0];
          depth_of[nx] = depth_of[cur] + 6'd1;
          fail_of[nx] = '0;
          suffix_of[nx] = '0;
          is_final[nx] = 1'b0;
        end
      end
      if (!err) cur = nx;
    end
    if (lst) begin
      if (!err) begin
        is_final[cur] = 1'b1;
        pat_of[cur] = next_pat_id;
        next_pat_id = next_pat_id + 8'd1;
      end
      cur = 0;
    end
    ins_node = cur;
    return err ? mpsm_pkg::KindFull : mpsm_pkg::KindDone;
  endfunction

  function automatic void link_trie();
    int unsigned head, tail, u, v, f, g;
    head = 0;
    tail = 0;
    fail_of[0] = '0;
    suffix_of[0] = '0;
    bfs_fifo[tail++] = '0;
    while (head < tail) begin
      u = bfs_fifo[head++];
      for (int c = 0; c < NSymbols; c++) begin
        v = next_of(u, c);
        f = 0;
        if (v == 0 || tail >= NStates) continue;
        if (u != 0) begin
          f = fail_of[u];
          while (f != 0 && next_of(f, c) == 0) f = fail_of[f];
          g = next_of(f, c);
          f = (g != 0 && g != v) ? g : 0;
        end
        fail_of[v] = f[7:0];
        suffix_of[v] = is_final[f] ? f[7:0] : suffix_of[f];
        bfs_fifo[tail++] = v[7:0];
      end
    end
  endfunction

  function automatic void scan_char(int unsigned c);
    int unsigned s, n, guard, k, d, st;
    k = 0;
    s = cur_node % NStates;
    if (pos_in_text < 16'hFFFF) pos_in_text++;
    if (c >= NSymbols) begin
      s = 0;
    end else begin
      guard = 0;
      while (s != 0 && next_of(s, c) == 0 && guard < NStates) begin
        s = fail_of[s];
        guard++;
      end
      s = next_of(s, c);
    end
    cur_node = s;
    n = s;
    guard = 0;
    while (n != 0 && k < mpsm_pkg::ResMax && guard < NStates) begin
      if (is_final[n]) begin
        d = depth_of[n];
        st = (d <= pos_in_text) ? pos_in_text - d + 1 : 0;
        expect_res(mk(mpsm_pkg::KindMatch, pat_of[n], st[15:0], 1'b0));
        k++;
      end
      n = suffix_of[n];
      guard++;
    end
    if (k == 0) expect_res(mk(mpsm_pkg::KindNone, '0, '0, 1'b1));
    else match_q[$].last = 1'b1;
  endfunction

  function automatic void predict(mpsm_pkg::req_t r);
    case (r.req_type)
      mpsm_pkg::ReqClear: begin
        wipe_trie();
        expect_res(mk(mpsm_pkg::KindDone, '0, '0, 1'b1));
      end
      mpsm_pkg::ReqInsert: expect_res(mk(add_char(r.symbol, r.last_char), '0, '0, 1'b1));
      mpsm_pkg::ReqBuild: begin
        link_trie();
        expect_res(mk(mpsm_pkg::KindDone, '0, '0, 1'b1));
      end
      default: begin
        if (r.text_start) begin
          cur_node = 0;
          pos_in_text = 0;
        end
        scan_char(r.symbol);
      end
    endcase
  endfunction

  function automatic mpsm_pkg::req_t rq(logic [1:0] t, int unsigned sym, bit lst, bit ts);
    mpsm_pkg::req_t r;
    r.req_type = t;
    r.symbol = sym[6:0];
    r.last_char = lst;
    r.text_start = ts;
    return r;
  endfunction

  // Offers one request, with burst gaps, and records its expected results on acceptance.
  task automatic send(mpsm_pkg::req_t r, bit typed = 1'b0, mpsm_pkg::res_t want = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict(r);
    if (typed) begin
      void'(match_q.pop_back());
      expect_res(want);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (match_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic add_word(int unsigned len, int unsigned base, int unsigned span);
    for (int unsigned i = 0; i < len; i++)
      send(rq(mpsm_pkg::ReqInsert, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                   : base + $urandom_range(0, span),
              i == len - 1, $urandom_range(0, 1)));
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    mpsm_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (match_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res_o);
      end else begin
        want = match_q.pop_front();
        if (out_res_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_res_o);
        end
      end
    end
  end

  // Receiver with its own stall pattern and a long hold-off on request.
  always @(posedge clk_i) begin
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned mode;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL multi_pattern_string_matcher_top");
      $finish;
    end
    if (cycles % 64 == 0) mode = $urandom_range(0, 2);
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (mode == 0) begin
      out_ready_i <= 1'b1;
    end else if (mode == 1) begin
      out_ready_i <= $urandom_range(0, 1);
    end else begin
      out_ready_i <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned base, span, len;
    wipe_trie();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: classic dictionary plus extreme symbols.
    add_row(rq(mpsm_pkg::ReqText, 120, 0, 1), 1'b1, mk(mpsm_pkg::KindNone, '0, '0, 1'b1));
    add_row(rq(mpsm_pkg::ReqClear, 0, 0, 0), 1'b1, mk(mpsm_pkg::KindDone, '0, '0, 1'b1));
    add_row(rq(mpsm_pkg::ReqInsert, "h", 0, 0), 1'b1, mk(mpsm_pkg::KindDone, '0, '0, 1'b1));
    add_row(rq(mpsm_pkg::ReqInsert, "e", 1, 0), 1'b1, mk(mpsm_pkg::KindDone, '0, '0, 1'b1));
    add_row(rq(mpsm_pkg::ReqInsert, "s", 0, 1), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "h", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "e", 1, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "h", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "e", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "r", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "s", 1, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, 127, 1, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, 0, 1, 1), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, "h", 0, 1), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqBuild, 0, 0, 0), 1'b1, mk(mpsm_pkg::KindDone, '0, '0, 1'b1));
    add_row(rq(mpsm_pkg::ReqText, "u", 0, 1), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, "s", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, "h", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, "e", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, "r", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, "s", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, 127, 1, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqText, 0, 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "h", 0, 0), 1'b0, '0);
    add_row(rq(mpsm_pkg::ReqInsert, "e", 1, 0), 1'b0, '0);
    foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].want);
    drain();

    // Random rounds: a small dictionary over a narrow alphabet, then text.
    for (int round = 0; round < 2; round++) begin
      if (round == 0) send(rq(mpsm_pkg::ReqClear, $urandom_range(0, 127),
                              $urandom_range(0, 1), $urandom_range(0, 1)));
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = 124;
        default: base = $urandom_range(0, 124);
      endcase
      span = $urandom_range(1, 3);
      repeat ($urandom_range(2, 5)) add_word($urandom_range(1, 4), base, span);
      if ($urandom_range(0, 4) != 0) send(rq(mpsm_pkg::ReqBuild, $urandom_range(0, 127), 0, 0));
      if (round == 1) hold_gen <= hold_gen + 1;
      for (int i = 0; i < 10; i++)
        send(rq(mpsm_pkg::ReqText, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                   : base + $urandom_range(0, span),
                $urandom_range(0, 1), i == 0 || $urandom_range(0, 14) == 0));
      repeat (2) send(rq(2'($urandom_range(1, 3)), $urandom_range(0, 127),
                         $urandom_range(0, 1), $urandom_range(0, 1)));
      drain();
    end

    // Fill the node table; the first pattern is one character too long and the
    // last character of the final pattern finds the table full.
    send(rq(mpsm_pkg::ReqClear, 0, 0, 0));
    for (int p = 0; p < 8; p++) begin
      len = (p == 0) ? MaxLen + 1 : MaxLen;
      for (int unsigned i = 0; i < len; i++)
        send(rq(mpsm_pkg::ReqInsert, (i == 0) ? 10 + p : $urandom_range(0, 127),
                i == len - 1, 0));
    end
    send(rq(mpsm_pkg::ReqBuild, 0, 0, 0));
    for (int i = 0; i < 4; i++) send(rq(mpsm_pkg::ReqText, $urandom_range(10, 13), 0, i == 0));
    drain();

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && match_q.size() == 0) begin
      $display("PASS multi_pattern_string_matcher_top");
    end else begin
      $display("FAIL multi_pattern_string_matcher_top");
    end
    $finish;
  end

endmodule
